// ===== rtl/timer_prescaler_compare_solver_top_defines.svh =====
// ----------------------------------------------------------------------------
// Timer prescaler solver assertion macros
// Shared concurrent assertion forms for the checker of the solver.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_COMPARE_SOLVER_TOP_DEFINES_SVH
`define TIMER_PRESCALER_COMPARE_SOLVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPCS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== rtl/tpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler solver package
// Types, constants and prescaler table functions shared by the solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpcs_pkg;

	localparam int CLK_W   = 27;
	localparam int FREQ_W  = 32;
	localparam int SEL_W   = 2;
	localparam int CODE_W  = 3;
	localparam int CMP_W   = 16;
	localparam int ACH_W   = 26;
	localparam int SHIFT_W = 4;
	localparam int CNT_W   = $clog2(CLK_W + 1);

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(16000000);
	localparam logic [CMP_W-1:0] LIMIT_8   = CMP_W'(255);
	localparam logic [CMP_W-1:0] LIMIT_16  = CMP_W'(65535);

	localparam logic [SEL_W-1:0] SEL_T8_SHORT  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_T16_SHORT = 2'd1;
	localparam logic [SEL_W-1:0] SEL_T8_LONG   = 2'd2;
	localparam logic [SEL_W-1:0] SEL_INVALID   = 2'd3;

	localparam logic [CODE_W-1:0] CODE_FIRST      = 3'd1;
	localparam logic [CODE_W-1:0] CODE_LAST_SHORT = 3'd5;
	localparam logic [CODE_W-1:0] CODE_LAST_LONG  = 3'd7;

	typedef struct packed {
		logic [SEL_W-1:0]  timer_select;
		logic [FREQ_W-1:0] target_freq;
	} tpcs_in_t;

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] clock_select;
		logic [CMP_W-1:0]  compare_value;
		logic              overflow_mode;
		logic [ACH_W-1:0]  achieved_freq;
	} tpcs_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START,
		ST_SEARCH,
		ST_EVAL,
		ST_ACH,
		ST_WRITE
	} tpcs_state_t;

	typedef struct packed {
		logic load;
		logic start_search;
		logic start_ach;
		logic next_code;
		logic mark_fail;
		logic write_out;
	} tpcs_cmd_t;

	typedef struct packed {
		logic bad;
		logic div_busy;
		logic fits;
		logic last;
		logic out_free;
	} tpcs_status_t;

	// Log2 of the prescale factor for a clock code.
	function automatic logic [SHIFT_W-1:0] prescale_shift(input logic long_tab,
		input logic [CODE_W-1:0] code);
		logic [SHIFT_W-1:0] s;
		s = '0;
		if (long_tab) begin
			unique case (code)
				3'd2: s = 4'd3;
				3'd3: s = 4'd5;
				3'd4: s = 4'd6;
				3'd5: s = 4'd7;
				3'd6: s = 4'd8;
				3'd7: s = 4'd10;
				default: s = 4'd0;
			endcase
		end else begin
			unique case (code)
				3'd2: s = 4'd3;
				3'd3: s = 4'd6;
				3'd4: s = 4'd8;
				3'd5: s = 4'd10;
				default: s = 4'd0;
			endcase
		end
		return s;
	endfunction

endpackage

// ===== rtl/tpcs_div.sv =====
// ----------------------------------------------------------------------------
// Solver divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpcs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpcs_pkg::CLK_W-1:0]  dividend,
	input  logic [tpcs_pkg::FREQ_W-1:0] divisor,
	output logic                        busy,
	output logic [tpcs_pkg::CLK_W-1:0]  quotient
);
	import tpcs_pkg::*;

	logic [CNT_W-1:0]  cnt_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dvs_q;
	logic [CLK_W-1:0]  dvd_q;
	logic [FREQ_W:0]   trial;
	logic [FREQ_W:0]   diff;
	logic              bit_one;

	assign trial   = {rem_q, dvd_q[CLK_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign bit_one = !diff[FREQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(CLK_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= dividend;
		end else if (busy) begin
			rem_q <= bit_one ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			dvd_q <= {dvd_q[CLK_W-2:0], bit_one};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = dvd_q;

endmodule

// ===== rtl/tpcs_dp.sv =====
// ----------------------------------------------------------------------------
// Solver datapath
// Holds the clock register, the item, the search code and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpcs_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [tpcs_pkg::CLK_W-1:0] cfg_data,
	input  tpcs_pkg::tpcs_in_t         in_data,
	input  tpcs_pkg::tpcs_cmd_t        cmd,
	output tpcs_pkg::tpcs_status_t     status,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tpcs_pkg::tpcs_out_t        out_data
);
	import tpcs_pkg::*;

	logic [CLK_W-1:0]   clk_hz_q;
	logic [SEL_W-1:0]   sel_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [CODE_W-1:0]  code_q;
	logic [CMP_W-1:0]   cmp_q;
	logic               ok_q;
	logic               out_valid_q;
	tpcs_out_t          out_q;
	logic               long_tab;
	logic [SHIFT_W-1:0] shift;
	logic [CLK_W-1:0]   dividend;
	logic [FREQ_W-1:0]  divisor;
	logic [CLK_W-1:0]   quo;
	logic [CLK_W-1:0]   cmp_full;
	logic [CMP_W-1:0]   limit;
	logic               div_busy;

	assign long_tab = (sel_q == SEL_T8_LONG);
	assign shift    = prescale_shift(long_tab, code_q);
	assign dividend = clk_hz_q >> (shift + 1'b1);
	assign divisor  = cmd.start_ach ? FREQ_W'(quo) : freq_q;
	assign cmp_full = quo - 1'b1;
	assign limit    = (sel_q == SEL_T16_SHORT) ? LIMIT_16 : LIMIT_8;

	tpcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_search || cmd.start_ach),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_valid) begin
			clk_hz_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sel_q  <= in_data.timer_select;
			freq_q <= in_data.target_freq;
			code_q <= CODE_FIRST;
		end else if (cmd.next_code) begin
			code_q <= code_q + 1'b1;
		end
		if (cmd.start_ach) begin
			cmp_q <= cmp_full[CMP_W-1:0];
			ok_q  <= 1'b1;
		end else if (cmd.mark_fail) begin
			ok_q <= 1'b0;
		end
		if (cmd.write_out) begin
			if (ok_q) begin
				out_q.ok            <= 1'b1;
				out_q.clock_select  <= code_q;
				out_q.compare_value <= cmp_q;
				out_q.overflow_mode <= (cmp_q == '0);
				out_q.achieved_freq <= quo[ACH_W-1:0];
			end else begin
				out_q <= '0;
			end
		end
	end

	assign status.bad      = (sel_q == SEL_INVALID) || (freq_q == '0)
		|| (freq_q > FREQ_W'(clk_hz_q >> 1));
	assign status.div_busy = div_busy;
	assign status.fits     = (quo != '0) && (cmp_full <= CLK_W'(limit));
	assign status.last     = long_tab ? (code_q == CODE_LAST_LONG)
		: (code_q == CODE_LAST_SHORT);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/tpcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Solver controller
// Sequences the check, the prescaler search and the result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpcs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tpcs_pkg::tpcs_status_t status,
	output tpcs_pkg::tpcs_cmd_t    cmd
);
	import tpcs_pkg::*;

	tpcs_state_t state_q;
	tpcs_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
			ST_CHECK:  state_nxt = status.bad ? ST_WRITE : ST_START;
			ST_START:  state_nxt = ST_SEARCH;
			ST_SEARCH: if (!status.div_busy) state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (status.fits) begin
					state_nxt = ST_ACH;
				end else if (status.last) begin
					state_nxt = ST_WRITE;
				end else begin
					state_nxt = ST_START;
				end
			end
			ST_ACH:    if (!status.div_busy) state_nxt = ST_WRITE;
			ST_WRITE:  if (status.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK:  cmd.mark_fail = status.bad;
			ST_START:  cmd.start_search = 1'b1;
			ST_SEARCH: ;
			ST_EVAL: begin
				cmd.start_ach = status.fits;
				cmd.mark_fail = !status.fits && status.last;
				cmd.next_code = !status.fits && !status.last;
			end
			ST_ACH:    ;
			ST_WRITE:  cmd.write_out = status.out_free;
			default:   ;
		endcase
	end

endmodule

// ===== rtl/timer_prescaler_compare_solver_top.sv =====
// One item is handled at a time. After a transfer the block checks the item in its
// check state, then tries the prescaler codes from code 1 upward; each code takes one
// run of the shared 27-step radix-2 divider, and the achieved frequency takes one more
// division. A rejected item goes straight to the write state, and the longest search
// tries all seven long-table codes. The result waits in an output register, so a new
// item is taken while the previous result has not yet been transferred. The clock
// register is written through its own port, which is always ready; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
// Timer prescaler solver top level
// Finds the prescaler code and compare value for a wanted toggle frequency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timer_prescaler_compare_solver_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tpcs_pkg::CLK_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  tpcs_pkg::tpcs_in_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tpcs_pkg::tpcs_out_t        out_data
);
	import tpcs_pkg::*;

	tpcs_cmd_t    cmd;
	tpcs_status_t status;

	assign cfg_ready = 1'b1;

	tpcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tpcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/tpcs_checker.sv =====
// ----------------------------------------------------------------------------
// Solver port checker
// Watches the ports of the solver top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timer_prescaler_compare_solver_top_defines.svh"

module tpcs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tpcs_pkg::tpcs_out_t out_data
);
	import tpcs_pkg::*;

	`TPCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`TPCS_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	`TPCS_ASSERT_IMPLY(a_fail_zero, clk, arst_n, out_valid && !out_data.ok, out_data == '0)
	`TPCS_ASSERT_IMPLY(a_ok_fields, clk, arst_n, out_valid && out_data.ok, (out_data.clock_select != '0) && (out_data.overflow_mode == (out_data.compare_value == '0)))

endmodule

bind timer_prescaler_compare_solver_top tpcs_checker u_tpcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== tb/tb_timer_prescaler_compare_solver_top.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler solver testbench
// Feeds timer select and frequency requests through the input channel under
// several clock settings and idle patterns, predicts every solution in the
// bench itself and checks each transfer on the output channel field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timer_prescaler_compare_solver_top;

	import tpcs_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		tpcs_in_t  req;
		tpcs_out_t res;
	} solution_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CLK_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	tpcs_in_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	tpcs_out_t           out_data;

	tpcs_in_t            pending_requests[$];
	solution_t           expected_solutions[$];
	logic [CLK_W-1:0]    model_clock_hz = CLK_RESET;
	int                  sender_idle_pct = 0;
	int                  receiver_stall_pct = 0;
	int                  issued_requests = 0;
	int                  accepted_requests = 0;
	int                  checked_solutions = 0;
	int                  solved_count = 0;
	int                  clock_writes = 0;
	int                  mismatches = 0;
	int                  cycles = 0;

	timer_prescaler_compare_solver_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic tpcs_out_t solve_timer(input tpcs_in_t req, input logic [CLK_W-1:0] hz);
		tpcs_out_t   res;
		logic [63:0] hz64;
		logic [63:0] freq;
		logic [63:0] scale;
		logic [63:0] quot;
		logic [63:0] cmp;
		logic [63:0] limit;
		logic [63:0] ach;
		int          last_code;
		int          found;
		int          sh;
		logic        long_tab;
		logic        fits;
		res = '0;
		hz64 = 64'(hz);
		freq = 64'(req.target_freq);
		fits = 1'b0;
		found = 0;
		scale = 64'd1;
		cmp = '0;
		long_tab = 1'b0;
		case (req.timer_select)
			SEL_T8_SHORT: begin
				last_code = int'(CODE_LAST_SHORT);
				limit = 64'(LIMIT_8);
			end
			SEL_T16_SHORT: begin
				last_code = int'(CODE_LAST_SHORT);
				limit = 64'(LIMIT_16);
			end
			SEL_T8_LONG: begin
				last_code = int'(CODE_LAST_LONG);
				limit = 64'(LIMIT_8);
				long_tab = 1'b1;
			end
			default: begin
				return res;
			end
		endcase
		if (freq == 0 || freq > hz64 / 2)
			return res;
		for (int c = int'(CODE_FIRST); c <= last_code; c++) begin
			if (!fits) begin
				if (long_tab) begin
					case (c)
						2: sh = 3;
						3: sh = 5;
						4: sh = 6;
						5: sh = 7;
						6: sh = 8;
						7: sh = 10;
						default: sh = 0;
					endcase
				end else begin
					case (c)
						2: sh = 3;
						3: sh = 6;
						4: sh = 8;
						5: sh = 10;
						default: sh = 0;
					endcase
				end
				scale = 64'd1 << sh;
				quot = hz64 / (2 * freq * scale);
				if (quot != 0) begin
					cmp = quot - 1;
					if (cmp <= limit) begin
						fits = 1'b1;
						found = c;
					end
				end
			end
		end
		if (!fits)
			return res;
		ach = hz64 / (2 * scale * (cmp + 1));
		if (ach > 64'h3FFFFFF)
			ach = 64'h3FFFFFF;
		res.ok = 1'b1;
		res.clock_select = CODE_W'(found);
		res.compare_value = cmp[CMP_W-1:0];
		res.overflow_mode = (cmp == 0);
		res.achieved_freq = ach[ACH_W-1:0];
		return res;
	endfunction

	always @(negedge clk) begin : drive_requests
		logic     next_valid;
		tpcs_in_t next_req;
		next_valid = in_valid;
		if (in_valid && accepted_requests == issued_requests)
			next_valid = 1'b0;
		if (arst_n && !next_valid && pending_requests.size() > 0
				&& $urandom_range(99) >= sender_idle_pct) begin
			next_req = pending_requests.pop_front();
			in_data <= next_req;
			next_valid = 1'b1;
			issued_requests++;
		end
		in_valid <= next_valid;
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin : watch_transfers
		solution_t exp_sol;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_clock_hz = cfg_data;
			if (in_valid && in_ready) begin
				exp_sol.req = in_data;
				exp_sol.res = solve_timer(in_data, model_clock_hz);
				expected_solutions.push_back(exp_sol);
				accepted_requests++;
			end
			if (out_valid && out_ready) begin
				if (expected_solutions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: ok=%0d cs=%0d cmp=%0d ovf=%0d ach=%0d",
							out_data.ok, out_data.clock_select, out_data.compare_value,
							out_data.overflow_mode, out_data.achieved_freq);
				end else begin
					exp_sol = expected_solutions.pop_front();
					checked_solutions++;
					if (exp_sol.res.ok)
						solved_count++;
					if (out_data.ok !== exp_sol.res.ok
							|| out_data.clock_select !== exp_sol.res.clock_select
							|| out_data.compare_value !== exp_sol.res.compare_value
							|| out_data.overflow_mode !== exp_sol.res.overflow_mode
							|| out_data.achieved_freq !== exp_sol.res.achieved_freq) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch sel=%0d freq=%0d clock=%0d", exp_sol.req.timer_select,
								exp_sol.req.target_freq, model_clock_hz);
							$display("  expected ok=%0d cs=%0d cmp=%0d ovf=%0d ach=%0d",
								exp_sol.res.ok, exp_sol.res.clock_select,
								exp_sol.res.compare_value, exp_sol.res.overflow_mode,
								exp_sol.res.achieved_freq);
							$display("  actual   ok=%0d cs=%0d cmp=%0d ovf=%0d ach=%0d",
								out_data.ok, out_data.clock_select, out_data.compare_value,
								out_data.overflow_mode, out_data.achieved_freq);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_timer_prescaler_compare_solver_top: FAIL");
			$finish;
		end
	end

	task automatic write_clock_hz(input logic [CLK_W-1:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		clock_writes++;
	endtask

	task automatic wait_drain();
		while (!(pending_requests.size() == 0 && accepted_requests == issued_requests
				&& expected_solutions.size() == 0))
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic add_request(input logic [SEL_W-1:0] sel, input logic [FREQ_W-1:0] freq);
		tpcs_in_t req;
		req.timer_select = sel;
		req.target_freq = freq;
		pending_requests.push_back(req);
	endtask

	task automatic add_random_requests(input int count, input logic [CLK_W-1:0] hz);
		logic [31:0]       half;
		logic [SEL_W-1:0]  sel;
		logic [FREQ_W-1:0] freq;
		int                pick;
		half = 32'(hz) / 2;
		for (int n = 0; n < count; n++) begin
			sel = ($urandom_range(99) < 8) ? SEL_INVALID : SEL_W'($urandom_range(0, 2));
			pick = $urandom_range(99);
			if (pick < 8)
				freq = $urandom;
			else if (pick < 11)
				freq = '0;
			else if (pick < 14)
				freq = half;
			else if (pick < 16)
				freq = half + 1;
			else if (half == 0)
				freq = $urandom_range(1, 3);
			else
				freq = 1 + (($urandom % half) >> $urandom_range(0, 26));
			add_request(sel, freq);
		end
	endtask

	task automatic run_phase(input logic [CLK_W-1:0] hz, input int idle, input int stall,
		input int count);
		sender_idle_pct = idle;
		receiver_stall_pct = stall;
		add_random_requests(count / 2, hz);
		wait_drain();
		add_random_requests(count - count / 2, hz);
		wait_drain();
	endtask

	initial begin
		logic [FREQ_W-1:0] edge_freqs[5];
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		edge_freqs[0] = 32'd1;
		edge_freqs[1] = 32'd0;
		edge_freqs[2] = 32'd8000000;
		edge_freqs[3] = 32'd8000001;
		edge_freqs[4] = 32'hFFFFFFFF;
		for (int s = 0; s < 4; s++)
			for (int f = 0; f < 5; f++)
				add_request(SEL_W'(s), edge_freqs[f]);
		add_request(SEL_T8_SHORT, 32'd31250);
		add_request(SEL_T8_LONG, 32'd8);
		add_request(SEL_T16_SHORT, 32'd123);
		wait_drain();

		run_phase(CLK_RESET, 0, 0, 330);
		write_clock_hz(CLK_W'(100000000));
		run_phase(CLK_W'(100000000), 45, 0, 330);
		write_clock_hz(CLK_W'(1));
		run_phase(CLK_W'(1), 0, 45, 80);
		write_clock_hz('1);
		run_phase('1, 31, 31, 330);
		begin
			logic [CLK_W-1:0] hz;
			hz = CLK_W'($urandom_range(2, 100000000));
			write_clock_hz(hz);
			run_phase(hz, 0, 45, 330);
			hz = CLK_W'($urandom_range(2, 5000));
			write_clock_hz(hz);
			run_phase(hz, 31, 31, 200);
		end
		write_clock_hz(CLK_RESET);
		run_phase(CLK_RESET, 45, 45, 270);

		repeat (30) @(posedge clk);
		if (expected_solutions.size() != 0)
			mismatches += expected_solutions.size();
		$display("Checked %0d solutions (%0d solved) from %0d requests over %0d clock writes.",
			checked_solutions, solved_count, accepted_requests, clock_writes);
		$display("Mismatches: %0d, cycles used: %0d.", mismatches, cycles);
		if (mismatches == 0) begin
			$display("tb_timer_prescaler_compare_solver_top: PASS");
		end else begin
			$display("tb_timer_prescaler_compare_solver_top: FAIL");
		end
		$finish;
	end

endmodule
